// File: sv/msr_pkg.sv
package msr_pkg;

  localparam int MB    = 31;
  localparam int CNT_W = 5;
  localparam int NR_W  = 13;
  localparam logic [NR_W-1:0] NR_LIMIT = NR_W'(4096);

  typedef struct packed {
    logic [MB-1:0] value;
    logic [MB-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic          is_residue;
    logic [MB-1:0] root;
  } out_t;

  typedef struct packed {
    logic          start;
    logic          pow;
    logic [MB-1:0] opa;
    logic [MB-1:0] opb;
  } eu_req_t;

  typedef struct packed {
    logic          done;
    logic [MB-1:0] res;
  } eu_rsp_t;

endpackage

// File: sv/msr_mulmod.sv
module msr_mulmod (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [msr_pkg::MB-1:0] a,
  input  logic [msr_pkg::MB-1:0] b,
  input  logic [msr_pkg::MB-1:0] m,
  output logic                   done,
  output logic [msr_pkg::MB-1:0] res
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [msr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [msr_pkg::MB-1:0]    r_r, r_nxt;
  logic [msr_pkg::MB-1:0]    a_r, a_nxt;
  logic [msr_pkg::MB-1:0]    b_r, b_nxt;
  logic [msr_pkg::MB:0]      m_w, d_w, r2_w, s_w, r3_w;

  always_comb begin
    m_w  = {1'b0, m};
    d_w  = {r_r, 1'b0};
    r2_w = (d_w >= m_w) ? d_w - m_w : d_w;
    s_w  = r2_w + {1'b0, a_r};
    if (b_r[msr_pkg::MB-1]) begin
      r3_w = (s_w >= m_w) ? s_w - m_w : s_w;
    end else begin
      r3_w = r2_w;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    r_nxt    = r_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      r_nxt    = '0;
      a_nxt    = a;
      b_nxt    = b;
    end else if (busy_r) begin
      r_nxt   = r3_w[msr_pkg::MB-1:0];
      b_nxt   = {b_r[msr_pkg::MB-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == msr_pkg::CNT_W'(msr_pkg::MB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    r_r <= r_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign res  = r_r;

endmodule

// File: sv/msr_expo.sv
module msr_expo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msr_pkg::eu_req_t       req,
  input  logic [msr_pkg::MB-1:0] m,
  output msr_pkg::eu_rsp_t       rsp
);

  typedef enum logic [4:0] {
    E_IDLE  = 5'b00001,
    E_ONE   = 5'b00010,
    E_CHECK = 5'b00100,
    E_ACC   = 5'b01000,
    E_SQR   = 5'b10000
  } est_t;

  est_t                   st_r, st_nxt;
  logic [msr_pkg::MB-1:0] acc_r, acc_nxt;
  logic [msr_pkg::MB-1:0] base_r, base_nxt;
  logic [msr_pkg::MB-1:0] exp_r, exp_nxt;
  logic [msr_pkg::MB-1:0] res_r, res_nxt;
  logic                   done_r, done_nxt;
  logic                   m_start;
  logic [msr_pkg::MB-1:0] m_a, m_b, m_res;
  logic                   m_done;

  msr_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m_start),
    .a     (m_a),
    .b     (m_b),
    .m     (m),
    .done  (m_done),
    .res   (m_res)
  );

  always_comb begin
    st_nxt   = st_r;
    acc_nxt  = acc_r;
    base_nxt = base_r;
    exp_nxt  = exp_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    m_start  = 1'b0;
    m_a      = base_r;
    m_b      = base_r;
    case (st_r)
      E_IDLE: begin
        if (req.start) begin
          if (req.pow) begin
            acc_nxt  = msr_pkg::MB'(1);
            base_nxt = req.opa;
            exp_nxt  = req.opb;
            st_nxt   = E_CHECK;
          end else begin
            m_start = 1'b1;
            m_a     = req.opa;
            m_b     = req.opb;
            st_nxt  = E_ONE;
          end
        end
      end
      E_ONE: begin
        if (m_done) begin
          res_nxt  = m_res;
          done_nxt = 1'b1;
          st_nxt   = E_IDLE;
        end
      end
      E_CHECK: begin
        if (exp_r == '0) begin
          res_nxt  = acc_r;
          done_nxt = 1'b1;
          st_nxt   = E_IDLE;
        end else if (exp_r[0]) begin
          m_start = 1'b1;
          m_a     = acc_r;
          m_b     = base_r;
          st_nxt  = E_ACC;
        end else begin
          m_start = 1'b1;
          st_nxt  = E_SQR;
        end
      end
      E_ACC: begin
        if (m_done) begin
          acc_nxt = m_res;
          m_start = 1'b1;
          st_nxt  = E_SQR;
        end
      end
      E_SQR: begin
        if (m_done) begin
          base_nxt = m_res;
          exp_nxt  = exp_r >> 1;
          st_nxt   = E_CHECK;
        end
      end
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// File: sv/modular_square_root.sv
// Modular square root by Tonelli-Shanks for a modulus of 2 or an odd prime. One
// transaction is taken at a time; in_stall stays high until its result is
// loaded into the output register. All arithmetic runs through a single
// bit-serial modular multiplier driven by a square-and-multiply exponent
// sequencer. A transaction costs the value reduction, the Euler test, one
// exponentiation per candidate of the non-residue search, two setup
// exponentiations and up to two exponentiations per correction round.
module modular_square_root (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  msr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output msr_pkg::out_t out_data
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'b0000000000000000001,
    S_START = 19'b0000000000000000010,
    S_RED   = 19'b0000000000000000100,
    S_EUL   = 19'b0000000000000001000,
    S_NRS   = 19'b0000000000000010000,
    S_NRW   = 19'b0000000000000100000,
    S_FAC   = 19'b0000000000001000000,
    S_XW    = 19'b0000000000010000000,
    S_IW    = 19'b0000000000100000000,
    S_E1    = 19'b0000000001000000000,
    S_E1W   = 19'b0000000010000000000,
    S_E2W   = 19'b0000000100000000000,
    S_LOOP  = 19'b0000001000000000000,
    S_LPW   = 19'b0000010000000000000,
    S_LBW   = 19'b0000100000000000000,
    S_LXW   = 19'b0001000000000000000,
    S_LUPD  = 19'b0010000000000000000,
    S_FIN   = 19'b0100000000000000000,
    S_XREQ  = 19'b1000000000000000000
  } st_t;

  localparam int MB = msr_pkg::MB;

  st_t                         st_r, st_nxt;
  logic [MB-1:0]               p_r, p_nxt;
  logic [MB-1:0]               v_r, v_nxt;
  logic [MB-1:0]               a_r, a_nxt;
  logic [MB-1:0]               half_r, half_nxt;
  logic [msr_pkg::NR_W-1:0]    c_r, c_nxt;
  logic [MB-1:0]               b_r, b_nxt;
  logic [MB-1:0]               s_r, s_nxt;
  logic [msr_pkg::CNT_W-1:0]   t_r, t_nxt;
  logic [msr_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [MB-1:0]               x_r, x_nxt;
  logic [MB-1:0]               ainv_r, ainv_nxt;
  logic [MB-1:0]               e_r, e_nxt;
  logic [MB-1:0]               shb_r, shb_nxt;
  logic                        fres_r, fres_nxt;
  logic [MB-1:0]               froot_r, froot_nxt;
  logic                        ov_r, ov_nxt;
  msr_pkg::out_t               od_r, od_nxt;
  msr_pkg::eu_req_t            req;
  msr_pkg::eu_rsp_t            rsp;
  logic [MB:0]                 sp1_w;
  logic [msr_pkg::CNT_W-1:0]   sh_w;

  msr_expo u_expo (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .m     (p_r),
    .rsp   (rsp)
  );

  assign sp1_w = {1'b0, s_r} + (MB+1)'(1);
  assign sh_w  = t_r - k_r - msr_pkg::CNT_W'(1);

  always_comb begin
    st_nxt    = st_r;
    p_nxt     = p_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    half_nxt  = half_r;
    c_nxt     = c_r;
    b_nxt     = b_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    x_nxt     = x_r;
    ainv_nxt  = ainv_r;
    e_nxt     = e_r;
    shb_nxt   = shb_r;
    fres_nxt  = fres_r;
    froot_nxt = froot_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    req       = '0;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          p_nxt  = in_data.modulus;
          v_nxt  = in_data.value;
          st_nxt = S_START;
        end
      end
      S_START: begin
        fres_nxt  = 1'b0;
        froot_nxt = '0;
        if (p_r < MB'(2)) begin
          st_nxt = S_FIN;
        end else begin
          req.start = 1'b1;
          req.opa   = MB'(1);
          req.opb   = v_r;
          st_nxt    = S_RED;
        end
      end
      S_RED: begin
        if (rsp.done) begin
          a_nxt    = rsp.res;
          half_nxt = (p_r - MB'(1)) >> 1;
          if (p_r == MB'(2)) begin
            fres_nxt  = (rsp.res == MB'(1));
            froot_nxt = (rsp.res == MB'(1)) ? MB'(1) : '0;
            st_nxt    = S_FIN;
          end else if (!p_r[0]) begin
            st_nxt = S_FIN;
          end else begin
            req.start = 1'b1;
            req.pow   = 1'b1;
            req.opa   = rsp.res;
            req.opb   = (p_r - MB'(1)) >> 1;
            st_nxt    = S_EUL;
          end
        end
      end
      S_EUL: begin
        if (rsp.done) begin
          if (rsp.res != MB'(1)) begin
            st_nxt = S_FIN;
          end else begin
            c_nxt  = msr_pkg::NR_W'(2);
            st_nxt = S_NRS;
          end
        end
      end
      S_NRS: begin
        if ((MB'(c_r) < p_r) && (c_r <= msr_pkg::NR_LIMIT)) begin
          req.start = 1'b1;
          req.pow   = 1'b1;
          req.opa   = MB'(c_r);
          req.opb   = half_r;
          st_nxt    = S_NRW;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_NRW: begin
        if (rsp.done) begin
          if (rsp.res == p_r - MB'(1)) begin
            b_nxt  = MB'(c_r);
            s_nxt  = p_r - MB'(1);
            t_nxt  = '0;
            st_nxt = S_FAC;
          end else begin
            c_nxt  = c_r + msr_pkg::NR_W'(1);
            st_nxt = S_NRS;
          end
        end
      end
      S_FAC: begin
        if (!s_r[0]) begin
          s_nxt = s_r >> 1;
          t_nxt = t_r + msr_pkg::CNT_W'(1);
        end else begin
          st_nxt = S_XREQ;
        end
      end
      S_XREQ: begin
        req.start = 1'b1;
        req.pow   = 1'b1;
        req.opa   = a_r;
        req.opb   = sp1_w[MB:1];
        st_nxt    = S_XW;
      end
      S_XW: begin
        if (rsp.done) begin
          x_nxt     = rsp.res;
          req.start = 1'b1;
          req.pow   = 1'b1;
          req.opa   = a_r;
          req.opb   = p_r - MB'(2);
          st_nxt    = S_IW;
        end
      end
      S_IW: begin
        if (rsp.done) begin
          ainv_nxt = rsp.res;
          shb_nxt  = s_r;
          k_nxt    = msr_pkg::CNT_W'(1);
          st_nxt   = S_E1;
        end
      end
      S_E1: begin
        req.start = 1'b1;
        req.opa   = x_r;
        req.opb   = x_r;
        st_nxt    = S_E1W;
      end
      S_E1W: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.opa   = rsp.res;
          req.opb   = ainv_r;
          st_nxt    = S_E2W;
        end
      end
      S_E2W: begin
        if (rsp.done) begin
          e_nxt  = rsp.res;
          st_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        if (k_r < t_r) begin
          req.start = 1'b1;
          req.pow   = 1'b1;
          req.opa   = e_r;
          req.opb   = MB'(1) << sh_w;
          st_nxt    = S_LPW;
        end else begin
          fres_nxt  = 1'b1;
          froot_nxt = x_r;
          st_nxt    = S_FIN;
        end
      end
      S_LPW: begin
        if (rsp.done) begin
          if (rsp.res != MB'(1)) begin
            req.start = 1'b1;
            req.pow   = 1'b1;
            req.opa   = b_r;
            req.opb   = shb_r;
            st_nxt    = S_LBW;
          end else begin
            st_nxt = S_LUPD;
          end
        end
      end
      S_LBW: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.opa   = x_r;
          req.opb   = rsp.res;
          st_nxt    = S_LXW;
        end
      end
      S_LXW: begin
        if (rsp.done) begin
          x_nxt  = rsp.res;
          st_nxt = S_LUPD;
        end
      end
      S_LUPD: begin
        shb_nxt = shb_r << 1;
        k_nxt   = k_r + msr_pkg::CNT_W'(1);
        st_nxt  = S_E1;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt            = 1'b1;
          od_nxt.is_residue = fres_r;
          od_nxt.root       = froot_r;
          st_nxt            = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    p_r     <= p_nxt;
    v_r     <= v_nxt;
    a_r     <= a_nxt;
    half_r  <= half_nxt;
    c_r     <= c_nxt;
    b_r     <= b_nxt;
    s_r     <= s_nxt;
    t_r     <= t_nxt;
    k_r     <= k_nxt;
    x_r     <= x_nxt;
    ainv_r  <= ainv_nxt;
    e_r     <= e_nxt;
    shb_r   <= shb_nxt;
    fres_r  <= fres_nxt;
    froot_r <= froot_nxt;
    od_r    <= od_nxt;
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (st_r == S_START))
    else $error("accepted transaction did not start the sequencer");

  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_residue) |-> (out_data.root == '0))
    else $error("non-residue result carries a nonzero root");

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r))
    else $error("sequencer state lost its one-hot code");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && !out_stall) |=> out_valid)
    else $error("finished transaction not loaded into output register");

endmodule

// File: tb/modular_square_root_test.sv
`timescale 1ns / 100ps

module modular_square_root_test;

  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
  localparam int LONG_HOLD = 4000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    msr_pkg::in_t data;
    bit           drain_first;
  } pending_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  msr_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  msr_pkg::out_t out_data;

  pending_t      pending_q[$];
  msr_pkg::out_t root_q[$];
  int       errors = 0;
  int       accepted_cnt = 0;
  int       send_gap = 0;
  int       stall_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       quiet = 1'b0;
  bit       stim_done = 1'b0;
  longint unsigned cycle_cnt = 0;

  modular_square_root DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
    return (x * y) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned x, longint unsigned ex,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 64'd1 % m;
    x = x % m;
    while (ex != 0) begin
      if (ex[0]) acc = mul_mod(acc, x, m);
      x = mul_mod(x, x, m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  function automatic msr_pkg::out_t predict_root(msr_pkg::in_t d);
    msr_pkg::out_t r;
    longint unsigned p, a, half, b, s, x, a_inv, e, shift_b, c;
    int t;
    bit found;
    r = '0;
    p = 64'(d.modulus);
    if (p < 2) return r;
    a = 64'(d.value) % p;
    if (p == 2) begin
      if (a == 1) begin
        r.is_residue = 1'b1;
        r.root = msr_pkg::MB'(1);
      end
      return r;
    end
    if (p[0] == 1'b0) return r;
    half = (p - 1) / 2;
    if (pow_mod(a, half, p) != 1) return r;
    found = 1'b0;
    b = 0;
    for (c = 2; c < p && c <= 4096 && !found; c++) begin
      if (pow_mod(c, half, p) == p - 1) begin
        b = c;
        found = 1'b1;
      end
    end
    if (!found) return r;
    s = p - 1;
    t = 0;
    while (s[0] == 1'b0) begin
      s = s >> 1;
      t++;
    end
    x = pow_mod(a, (s + 1) / 2, p);
    a_inv = pow_mod(a, p - 2, p);
    e = mul_mod(mul_mod(x, x, p), a_inv, p);
    shift_b = s;
    for (int k = 1; k + 1 <= t; k++) begin
      if (pow_mod(e, 64'd1 << (t - 1 - k), p) != 1)
        x = mul_mod(x, pow_mod(b, shift_b, p), p);
      shift_b = shift_b << 1;
      e = mul_mod(mul_mod(x, x, p), a_inv, p);
    end
    r.is_residue = 1'b1;
    r.root = x[msr_pkg::MB-1:0];
    return r;
  endfunction

  function automatic bit is_prime(longint unsigned n);
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (longint unsigned d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic longint unsigned pick_prime();
    longint unsigned n;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      case ($urandom_range(0, 6))
        0: return 64'd2147483647;
        1: return 64'd998244353;
        2: return 64'd2013265921;
        3: return 64'd65537;
        4: return 64'd7340033;
        5: return 64'd17;
        default: return 64'd3;
      endcase
    end
    do begin
      if (sel < 70) n = 64'($urandom_range(3, 65535));
      else if (sel < 90) n = 64'($urandom_range(65536, 24'hffffff));
      else n = 64'($urandom_range(32'h0100_0000, 32'h7fff_ffff));
      n = n | 64'd1;
    end while (!is_prime(n));
    return n;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  task automatic add_item(longint unsigned v, longint unsigned p, bit drain);
    pending_t it;
    it.data.value = v[msr_pkg::MB-1:0];
    it.data.modulus = p[msr_pkg::MB-1:0];
    it.drain_first = drain;
    pending_q = {pending_q, it};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        root_q = {root_q, predict_root(in_data)};
        accepted_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first && root_q.size() != 0)) begin
          in_data <= pending_q[0].data;
          in_valid <= 1'b1;
          pending_q.pop_front();
          send_gap = next_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst_n) begin
      if ($urandom_range(0, 4999) == 0) quiet = !quiet;
      if (!hold_done && accepted_cnt >= 2) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = next_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (root_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual %0d/%0d", $time,
                 out_data.is_residue, out_data.root);
        errors++;
      end else begin
        if (out_data.is_residue !== root_q[0].is_residue) begin
          $display("%0t: is_residue expected %0d actual %0d", $time,
                   root_q[0].is_residue, out_data.is_residue);
          errors++;
        end
        if (out_data.root !== root_q[0].root) begin
          $display("%0t: root expected %0d actual %0d", $time,
                   root_q[0].root, out_data.root);
          errors++;
        end
        root_q.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    longint unsigned p, r, v;
    int cat;
    // directed
    add_item(0, 2, 1'b0);
    add_item(1, 2, 1'b0);
    add_item(31'h7fff_ffff, 2, 1'b0);
    add_item(31'h7fff_fffe, 2, 1'b0);
    add_item(0, 17, 1'b0);
    add_item(5, 0, 1'b0);
    add_item(5, 1, 1'b0);
    add_item(9, 10, 1'b0);
    add_item(31'h7fff_ffff, 31'h7fff_fffe, 1'b0);
    add_item(4, 3, 1'b0);
    add_item(2, 3, 1'b0);
    add_item(13, 17, 1'b0);
    add_item(3, 17, 1'b0);
    add_item(35, 17, 1'b0);
    add_item(4, 9, 1'b0);
    add_item(7, 15, 1'b0);
    add_item(31'h7fff_ffff, 31'h7fff_ffff, 1'b0);
    add_item(31'h7fff_fffe, 31'h7fff_ffff, 1'b0);
    add_item(64'd1234567 * 64'd1234567 % 64'd2013265921, 2013265921, 1'b0);
    add_item(64'd777 * 64'd777 % 64'd998244353, 998244353, 1'b1);
    add_item(12345 * 12345 % 65537, 65537, 1'b0);
    add_item(3, 65537, 1'b0);
    add_item(1, 7340033, 1'b0);
    // random
    for (int n = 0; n < 80; n++) begin
      cat = $urandom_range(0, 99);
      p = pick_prime();
      if (cat < 60) begin
        r = $urandom % p;
        v = r * r % p;
      end else if (cat < 75) begin
        v = $urandom % p;
      end else if (cat < 83) begin
        v = 64'($urandom_range(0, 32'h7fff_ffff));
      end else if (cat < 88) begin
        p = 2;
        v = 64'($urandom_range(0, 32'h7fff_ffff));
      end else if (cat < 93) begin
        p = 64'($urandom_range(4, 400) | 1);
        v = $urandom % p;
      end else if (cat < 97) begin
        p = 64'((cat[0]) ? $urandom_range(0, 1)
                         : ($urandom_range(2, 32'h3fff_ffff) << 1));
        v = 64'($urandom_range(0, 32'h7fff_ffff));
      end else begin
        v = 0;
      end
      add_item(v, p, ($urandom_range(0, 29) == 0));
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (root_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && root_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: modular_square_root.f
sv/msr_pkg.sv
sv/msr_mulmod.sv
sv/msr_expo.sv
sv/modular_square_root.sv
tb/modular_square_root_test.sv
